// ===== src/cswq_pkg.sv =====
// shared constants and register codes for the semaphore waiter queue
package cswq_pkg;

  // parameter defaults
  localparam int WAIT_DEPTH_DEFAULT  = 16;
  localparam int THREAD_BITS_DEFAULT = 8;
  localparam int COUNT_BITS_DEFAULT  = 16;

  // most wake-ups that one release may cause
  localparam int MAX_RESULTS = 16;
  localparam int WAKE_BITS   = $clog2(MAX_RESULTS + 1);

  // configuration port
  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS  = 16;

  localparam logic [CFG_INDEX_BITS-1:0] REG_PERMIT_LIMIT    = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_INITIAL_PERMITS = 1'b1;

  localparam logic [CFG_DATA_BITS-1:0] LIMIT_RESET = '1;

  // input word mode
  localparam logic MODE_ACQUIRE = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

  // result status codes
  localparam int STATUS_BITS = 2;

  localparam logic [STATUS_BITS-1:0] ST_GRANTED  = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_QUEUED   = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_REJECTED = 2'd2;
  localparam logic [STATUS_BITS-1:0] ST_WOKEN    = 2'd3;

endpackage

// ===== src/cswq_wait_mem.sv =====
// waiter memory: one write port, one registered read port
module cswq_wait_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 24,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== src/cswq_rsp_reg.sv =====
// output register holding one result word for the receiver
module cswq_rsp_reg #(
  parameter int WIDTH = 27
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             free,
  output logic             valid,
  input  logic             stall,
  output logic [WIDTH-1:0] data
);

  // slot can take a new word when empty or being drained this cycle
  assign free = !valid || !stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (push) begin
      valid <= 1'b1;
    end else if (!stall) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      data <= push_data;
    end
  end

endmodule

// ===== src/counting_semaphore_waiter_queue.sv =====
// top level of the counting semaphore with a first-in first-out waiter queue
//
// request channel (req_valid / req_stall): one word per operation; mode 0
// acquires permit_count permits for thread_id, mode 1 releases permit_count
// permits. a word is taken when req_valid is high and req_stall is low.
// response channel (rsp_valid / rsp_stall): granted_thread, status,
// remaining_permits and last. an acquire gives exactly one word; a release
// gives one word per woken waiter (none if nobody wakes), last marks the
// final word of the operation.
// operation flow: one operation at a time. an acquire moves from acceptance to
// the exec state, which pushes its word into the output register once it is free.
// a release steps through acceptance, saturating add with the head read, and
// head check, then a wake-read step per woken waiter for the registered read of
// the waiter memory at the queue head; up to MAX_RESULTS waiters wake per release.
// reset (rst, synchronous): empty queue, zero permits, limit at all ones;
// no clearing pass, the waiter memory is only read at occupied slots.
// stalls: a stalled output word holds; the engine waits for the output
// register to free before making the next word, so nothing is lost.
// configuration: cfg_write with cfg_index 0 sets the permit limit, index 1
// loads the permit count only while the queue is empty; write while idle.
module counting_semaphore_waiter_queue #(
  parameter int WAIT_DEPTH  = cswq_pkg::WAIT_DEPTH_DEFAULT,
  parameter int THREAD_BITS = cswq_pkg::THREAD_BITS_DEFAULT,
  parameter int COUNT_BITS  = cswq_pkg::COUNT_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration write port
  input  logic                                cfg_write,
  input  logic [cswq_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [cswq_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  // request channel
  input  logic                                req_valid,
  output logic                                req_stall,
  input  logic                                mode,
  input  logic [THREAD_BITS-1:0]              thread_id,
  input  logic [COUNT_BITS-1:0]               permit_count,
  // response channel
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output logic [THREAD_BITS-1:0]              granted_thread,
  output logic [cswq_pkg::STATUS_BITS-1:0]    status,
  output logic [COUNT_BITS-1:0]               remaining_permits,
  output logic                                last
);

  localparam int PTR_W  = $clog2(WAIT_DEPTH);
  localparam int FILL_W = $clog2(WAIT_DEPTH + 1);
  localparam int MEM_W  = THREAD_BITS + COUNT_BITS;
  localparam int RSP_W  = THREAD_BITS + cswq_pkg::STATUS_BITS + COUNT_BITS + 1;
  localparam int WB     = cswq_pkg::WAKE_BITS;

  typedef enum logic [1:0] {
    IDLE,
    EXEC,
    WAKE_EVAL,
    WAKE_RD
  } state_t;

  // control state
  state_t                             state, state_next;
  logic [COUNT_BITS-1:0]              counter, counter_next;
  logic [PTR_W-1:0]                   head, head_next;
  logic [PTR_W-1:0]                   tail, tail_next;
  logic [FILL_W-1:0]                  fill, fill_next;
  logic [WB-1:0]                      wakes, wakes_next;
  logic                               have_pend, have_pend_next;
  logic [cswq_pkg::CFG_DATA_BITS-1:0] limit, limit_next;

  // operation being worked on
  logic                               item_mode;
  logic [THREAD_BITS-1:0]             item_thread;
  logic [COUNT_BITS-1:0]              item_count;

  // woken waiter held back until we know whether it is the last one
  logic [THREAD_BITS-1:0]             pend_thread;
  logic [COUNT_BITS-1:0]              pend_permits;

  logic                               accept;
  logic                               wake_take;
  logic                               mem_wr;
  logic [MEM_W-1:0]                   mem_rdata;
  logic [COUNT_BITS-1:0]              head_need;
  logic [THREAD_BITS-1:0]             head_thread;
  logic [COUNT_BITS-1:0]              lim;
  logic [COUNT_BITS:0]                sum;
  logic [COUNT_BITS-1:0]              clamped;
  logic                               can_wake;

  logic                               rsp_push;
  logic                               rsp_free;
  logic [RSP_W-1:0]                   rsp_word;
  logic [RSP_W-1:0]                   rsp_data;

  assign req_stall = (state != IDLE);
  assign accept    = req_valid && (state == IDLE);

  assign head_need   = mem_rdata[COUNT_BITS-1:0];
  assign head_thread = mem_rdata[COUNT_BITS +: THREAD_BITS];

  // saturating release add, limit masked to the count width
  assign lim     = COUNT_BITS'(limit);
  assign sum     = {1'b0, counter} + {1'b0, item_count};
  assign clamped = (sum > {1'b0, lim}) ? lim : sum[COUNT_BITS-1:0];

  // head waiter can be served from what the counter holds now
  assign can_wake = (wakes != WB'(cswq_pkg::MAX_RESULTS)) && (counter != '0) &&
                    (fill != '0) && (counter >= head_need);

  always_comb begin
    state_next     = state;
    counter_next   = counter;
    head_next      = head;
    tail_next      = tail;
    fill_next      = fill;
    wakes_next     = wakes;
    have_pend_next = have_pend;
    limit_next     = limit;
    wake_take      = 1'b0;
    mem_wr         = 1'b0;
    rsp_push       = 1'b0;
    rsp_word       = '0;

    // register writes are for the user to make only while idle; the block does not enforce it
    if (cfg_write) begin
      unique case (cfg_index)
        cswq_pkg::REG_PERMIT_LIMIT: begin
          limit_next = cfg_data;
        end
        cswq_pkg::REG_INITIAL_PERMITS: begin
          if (fill == '0) begin
            counter_next = COUNT_BITS'(cfg_data);
          end
        end
        default: begin
        end
      endcase
    end

    unique case (state)
      IDLE: begin
        if (accept) begin
          state_next = EXEC;
        end
      end

      EXEC: begin
        if (item_mode == cswq_pkg::MODE_RELEASE) begin
          // head entry is read during this cycle, ready in wake_eval
          counter_next   = clamped;
          wakes_next     = '0;
          have_pend_next = 1'b0;
          state_next     = WAKE_EVAL;
        end else if (rsp_free) begin
          rsp_push   = 1'b1;
          state_next = IDLE;
          if (counter >= item_count) begin
            counter_next = counter - item_count;
            rsp_word     = {item_thread, cswq_pkg::ST_GRANTED, counter - item_count, 1'b1};
          end else if (fill != FILL_W'(WAIT_DEPTH)) begin
            mem_wr    = 1'b1;
            tail_next = (tail == PTR_W'(WAIT_DEPTH - 1)) ? '0 : tail + 1'b1;
            fill_next = fill + 1'b1;
            rsp_word  = {item_thread, cswq_pkg::ST_QUEUED, counter, 1'b1};
          end else begin
            rsp_word  = {item_thread, cswq_pkg::ST_REJECTED, counter, 1'b1};
          end
        end
      end

      WAKE_EVAL: begin
        if (can_wake) begin
          if (!have_pend || rsp_free) begin
            // earlier wake is not the last one
            rsp_push       = have_pend;
            rsp_word       = {pend_thread, cswq_pkg::ST_WOKEN, pend_permits, 1'b0};
            wake_take      = 1'b1;
            counter_next   = counter - head_need;
            head_next      = (head == PTR_W'(WAIT_DEPTH - 1)) ? '0 : head + 1'b1;
            fill_next      = fill - 1'b1;
            wakes_next     = wakes + 1'b1;
            have_pend_next = 1'b1;
            state_next     = WAKE_RD;
          end
        end else if (!have_pend) begin
          state_next = IDLE;
        end else if (rsp_free) begin
          rsp_push       = 1'b1;
          rsp_word       = {pend_thread, cswq_pkg::ST_WOKEN, pend_permits, 1'b1};
          have_pend_next = 1'b0;
          state_next     = IDLE;
        end
      end

      WAKE_RD: begin
        // new head address goes to the memory this cycle
        state_next = WAKE_EVAL;
      end

      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      counter   <= '0;
      head      <= '0;
      tail      <= '0;
      fill      <= '0;
      wakes     <= '0;
      have_pend <= 1'b0;
      limit     <= cswq_pkg::LIMIT_RESET;
    end else begin
      state     <= state_next;
      counter   <= counter_next;
      head      <= head_next;
      tail      <= tail_next;
      fill      <= fill_next;
      wakes     <= wakes_next;
      have_pend <= have_pend_next;
      limit     <= limit_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      item_mode   <= mode;
      item_thread <= thread_id;
      item_count  <= permit_count;
    end
    if (wake_take) begin
      pend_thread  <= head_thread;
      pend_permits <= counter - head_need;
    end
  end

  cswq_wait_mem #(
    .DEPTH (WAIT_DEPTH),
    .WIDTH (MEM_W)
  ) u_wait_mem (
    .clk     (clk),
    .wr_en   (mem_wr),
    .wr_addr (tail),
    .wr_data ({item_thread, item_count}),
    .rd_addr (head),
    .rd_data (mem_rdata)
  );

  cswq_rsp_reg #(
    .WIDTH (RSP_W)
  ) u_rsp_reg (
    .clk       (clk),
    .rst       (rst),
    .push      (rsp_push),
    .push_data (rsp_word),
    .free      (rsp_free),
    .valid     (rsp_valid),
    .stall     (rsp_stall),
    .data      (rsp_data)
  );

  assign {granted_thread, status, remaining_permits, last} = rsp_data;

endmodule

// ===== src/cswq_checker.sv =====
// port-level checks for the semaphore waiter queue, bound to the top level
module cswq_checker #(
  parameter int THREAD_BITS = cswq_pkg::THREAD_BITS_DEFAULT,
  parameter int COUNT_BITS  = cswq_pkg::COUNT_BITS_DEFAULT
) (
  input logic                             clk,
  input logic                             rst,
  input logic                             req_valid,
  input logic                             req_stall,
  input logic                             rsp_valid,
  input logic                             rsp_stall,
  input logic [THREAD_BITS-1:0]           granted_thread,
  input logic [cswq_pkg::STATUS_BITS-1:0] status,
  input logic [COUNT_BITS-1:0]            remaining_permits,
  input logic                             last
);

  // a stalled word holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(granted_thread) &&
      $stable(status) && $stable(remaining_permits) && $stable(last))
    else $error("stalled response word changed");

  // nothing on the response side straight after reset
  a_rsp_reset: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid after reset");

  // one operation at a time: busy right after taking a word
  a_req_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request taken while previous one in flight");

  // acquire outcomes are always the single, final word
  a_acq_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status != cswq_pkg::ST_WOKEN) |-> last)
    else $error("acquire response without last");

endmodule

bind counting_semaphore_waiter_queue cswq_checker #(
  .THREAD_BITS (THREAD_BITS),
  .COUNT_BITS  (COUNT_BITS)
) u_cswq_checker (
  .clk               (clk),
  .rst               (rst),
  .req_valid         (req_valid),
  .req_stall         (req_stall),
  .rsp_valid         (rsp_valid),
  .rsp_stall         (rsp_stall),
  .granted_thread    (granted_thread),
  .status            (status),
  .remaining_permits (remaining_permits),
  .last              (last)
);

// ===== bench/tb.sv =====
// self-checking bench for the counting semaphore with its waiter queue
`timescale 1ns / 1ps

module tb;

  localparam int THR_W       = cswq_pkg::THREAD_BITS_DEFAULT;
  localparam int CNT_W       = cswq_pkg::COUNT_BITS_DEFAULT;
  localparam int QUEUE_SLOTS = cswq_pkg::WAIT_DEPTH_DEFAULT;
  localparam int ST_W        = cswq_pkg::STATUS_BITS;
  localparam int IDX_W       = cswq_pkg::CFG_INDEX_BITS;
  localparam int DAT_W       = cswq_pkg::CFG_DATA_BITS;
  // a release with nobody to wake leaves no word behind, so wait out the longest
  // walk (the add, then a wake-read step per waiter) before touching registers
  localparam int QUIET_CYCLES = 64;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 400;

  // one request word as the sender sees it
  typedef struct {
    logic             op;
    logic [THR_W-1:0] thread;
    logic [CNT_W-1:0] count;
  } sem_request_t;

  // one response word; packed so a whole word compares at once
  typedef struct packed {
    logic [THR_W-1:0] thread;
    logic [ST_W-1:0]  status;
    logic [CNT_W-1:0] remaining;
    logic             last;
  } sem_word_t;

  typedef struct {
    logic [THR_W-1:0] thread;
    logic [CNT_W-1:0] need;
  } sleeper_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic             cfg_write = 1'b0;
  logic [IDX_W-1:0] cfg_index = cswq_pkg::REG_PERMIT_LIMIT;
  logic [DAT_W-1:0] cfg_data  = '0;

  logic             req_valid    = 1'b0;
  logic             req_stall;
  logic             mode         = cswq_pkg::MODE_ACQUIRE;
  logic [THR_W-1:0] thread_id    = '0;
  logic [CNT_W-1:0] permit_count = '0;

  logic             rsp_valid;
  logic             rsp_stall = 1'b0;
  logic [THR_W-1:0] granted_thread;
  logic [ST_W-1:0]  status;
  logic [CNT_W-1:0] remaining_permits;
  logic             last;

  counting_semaphore_waiter_queue dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .req_valid        (req_valid),
    .req_stall        (req_stall),
    .mode             (mode),
    .thread_id        (thread_id),
    .permit_count     (permit_count),
    .rsp_valid        (rsp_valid),
    .rsp_stall        (rsp_stall),
    .granted_thread   (granted_thread),
    .status           (status),
    .remaining_permits(remaining_permits),
    .last             (last)
  );

  always #2 clk = ~clk;

  // words waiting to be offered, and words the semaphore should answer with
  sem_request_t pending_words[$];
  sem_word_t    due_words[$];

  // shadow copy of the semaphore: permits, registers and sleeping threads
  logic [CNT_W-1:0] shadow_permits;
  logic [DAT_W-1:0] shadow_limit;
  logic [DAT_W-1:0] shadow_initial;
  sleeper_t         sleepers[$];

  // run statistics
  int unsigned n_words_in, n_words_out, n_granted, n_queued, n_rejected, n_woken;
  int unsigned errors;

  // phase controls, only changed by the sequencer between clock edges
  bit gappy      = 1'b1;
  bit hold_armed = 1'b0;

  // idle length: mostly none or short, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!gappy || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // permit counts: mostly within the span of the phase, with the extremes
  // and full-width noise mixed in so every bit toggles
  function automatic logic [CNT_W-1:0] pick_count(input int unsigned span);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 6)  return CNT_W'($urandom());
    if (r < 10) return '0;
    if (r < 12) return '1;
    return CNT_W'($urandom_range(0, span));
  endfunction

  // work out the words one accepted request must produce
  task automatic predict_semaphore(input logic op, input logic [THR_W-1:0] thr,
                                   input logic [CNT_W-1:0] cnt);
    sem_word_t      w;
    sem_word_t      prev;
    bit             have_prev;
    logic [CNT_W:0] sum;
    int             n;
    n_words_in++;
    if (op == cswq_pkg::MODE_ACQUIRE) begin
      // granted at once whenever permits suffice, whoever is asleep
      if (shadow_permits >= cnt) begin
        shadow_permits = shadow_permits - cnt;
        w = '{thr, cswq_pkg::ST_GRANTED, shadow_permits, 1'b1};
        n_granted++;
      end else if (sleepers.size() < QUEUE_SLOTS) begin
        sleepers.push_back('{thr, cnt});
        w = '{thr, cswq_pkg::ST_QUEUED, shadow_permits, 1'b1};
        n_queued++;
      end else begin
        w = '{thr, cswq_pkg::ST_REJECTED, shadow_permits, 1'b1};
        n_rejected++;
      end
      due_words.push_back(w);
    end else begin
      // saturating add, then wake in arrival order up to MAX_RESULTS until one can't be met
      sum = {1'b0, shadow_permits} + cnt;
      if (sum > {1'b0, shadow_limit}) sum = {1'b0, shadow_limit};
      shadow_permits = sum[CNT_W-1:0];
      n = 0;
      have_prev = 1'b0;
      while (n < cswq_pkg::MAX_RESULTS && shadow_permits != 0 && sleepers.size() != 0 &&
             shadow_permits >= sleepers[0].need) begin
        shadow_permits = shadow_permits - sleepers[0].need;
        if (have_prev) due_words.push_back(prev);
        prev = '{sleepers[0].thread, cswq_pkg::ST_WOKEN, shadow_permits, 1'b0};
        have_prev = 1'b1;
        void'(sleepers.pop_front());
        n++;
        n_woken++;
      end
      // the final wake of a release carries last
      if (have_prev) begin
        prev.last = 1'b1;
        due_words.push_back(prev);
      end
    end
  endtask

  // sender: offers queued words with random gaps, keeps a stalled word steady,
  // and feeds every accepted word and register write to the shadow model
  int unsigned  send_gap;
  sem_request_t next_word;

  always @(posedge clk) begin
    if (rst) begin
      req_valid      <= 1'b0;
      send_gap       = 0;
      shadow_permits = '0;
      shadow_limit   = cswq_pkg::LIMIT_RESET;
      shadow_initial = '0;
      sleepers.delete();
    end else begin
      if (cfg_write) begin
        if (cfg_index == cswq_pkg::REG_PERMIT_LIMIT) begin
          shadow_limit = cfg_data;
        end else begin
          // loading the count only takes effect with nobody asleep
          shadow_initial = cfg_data;
          if (sleepers.size() == 0) shadow_permits = shadow_initial;
        end
      end
      if (req_valid && !req_stall) predict_semaphore(mode, thread_id, permit_count);
      if (!req_valid || !req_stall) begin
        if (send_gap > 0 || pending_words.size() == 0) begin
          if (send_gap > 0) send_gap--;
          req_valid <= 1'b0;
        end else begin
          next_word = pending_words.pop_front();
          mode         <= next_word.op;
          thread_id    <= next_word.thread;
          permit_count <= next_word.count;
          req_valid    <= 1'b1;
          send_gap     = pick_gap();
        end
      end
    end
  end

  // receiver stall: random gaps, plus one long hold-off so the block
  // backs up and has to stall its request side
  int unsigned stall_left, hold_left;
  bit          hold_done;

  always @(posedge clk) begin
    if (rst) begin
      rsp_stall  <= 1'b0;
      stall_left = 0;
      hold_left  = 0;
      hold_done  = 1'b0;
    end else begin
      if (hold_armed && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_stall <= 1'b1;
      end else begin
        stall_left = pick_gap();
        rsp_stall  <= 1'b0;
      end
    end
  end

  // checker: every taken word against the oldest outstanding prediction
  sem_word_t got_word, want_word;

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      got_word = '{granted_thread, status, remaining_permits, last};
      n_words_out++;
      if (due_words.size() == 0) begin
        errors++;
        $display("%0t: unexpected word thread %0d status %0d permits %0d last %0d",
                 $time, got_word.thread, got_word.status, got_word.remaining,
                 got_word.last);
      end else begin
        want_word = due_words.pop_front();
        if (got_word !== want_word) begin
          errors++;
          $display({"%0t: mismatch thread %0d/%0d status %0d/%0d permits %0d/%0d ",
                    "last %0d/%0d (expected/actual)"},
                   $time, want_word.thread, got_word.thread, want_word.status,
                   got_word.status, want_word.remaining, got_word.remaining,
                   want_word.last, got_word.last);
        end
      end
    end
  end

  // watchdog
  int unsigned cycles;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still due", cycles, due_words.size());
      $display("FAILURE");
      $finish;
    end
  end

  task automatic queue_word(input logic op, input logic [THR_W-1:0] thr,
                            input logic [CNT_W-1:0] cnt);
    pending_words.push_back('{op, thr, cnt});
  endtask

  // random traffic: mostly bursts of acquires closed by a release that may
  // wake some of them, the rest single words of either kind
  task automatic queue_traffic(input int unsigned total, input int unsigned span);
    int unsigned k, burst, i, rel;
    k = 0;
    while (k < total) begin
      if ($urandom_range(0, 99) < 70) begin
        burst = $urandom_range(1, 18);
        for (i = 0; i < burst && k < total; i++) begin
          queue_word(cswq_pkg::MODE_ACQUIRE, THR_W'($urandom_range(0, 255)),
                     pick_count(span));
          k++;
        end
        if (k < total) begin
          rel = $urandom_range(0, span * burst);
          if (rel > 65535) rel = 65535;
          queue_word(cswq_pkg::MODE_RELEASE, THR_W'($urandom_range(0, 255)), CNT_W'(rel));
          k++;
        end
      end else begin
        queue_word($urandom_range(0, 1) ? cswq_pkg::MODE_RELEASE : cswq_pkg::MODE_ACQUIRE,
                   THR_W'($urandom_range(0, 255)), pick_count(span));
        k++;
      end
    end
  endtask

  // wait for everything to go in and come out, then let the engine go quiet
  task automatic settle();
    do @(negedge clk);
    while (pending_words.size() != 0 || req_valid || due_words.size() != 0);
    repeat (QUIET_CYCLES) @(negedge clk);
  endtask

  // register write on the next edge; the caller lowers cfg_write afterwards
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DAT_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  int unsigned t, lim_pick;

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed part with the reset settings: limit all ones, no permits
    queue_word(cswq_pkg::MODE_ACQUIRE, 8'd0, 16'd0);       // zero permits, granted
    queue_word(cswq_pkg::MODE_ACQUIRE, 8'd255, 16'hFFFF);  // sleeps on an empty counter
    queue_word(cswq_pkg::MODE_RELEASE, 8'd0, 16'd0);       // nothing added, nobody wakes
    queue_word(cswq_pkg::MODE_RELEASE, 8'd0, 16'hFFFF);    // fills to the limit, wakes it
    for (t = 1; t <= QUEUE_SLOTS; t++) begin
      queue_word(cswq_pkg::MODE_ACQUIRE, THR_W'(t), 16'd1);
    end
    queue_word(cswq_pkg::MODE_ACQUIRE, 8'hAA, 16'd1);      // queue full, turned away
    queue_word(cswq_pkg::MODE_RELEASE, 8'h55, 16'hFFFF);   // wakes the whole queue at once
    queue_word(cswq_pkg::MODE_ACQUIRE, 8'd7, 16'hFFFF);    // left asleep
    queue_word(cswq_pkg::MODE_ACQUIRE, 8'd8, 16'd3);       // jumps ahead of the sleeper
    queue_word(cswq_pkg::MODE_RELEASE, 8'd0, 16'd1);       // too little for the sleeper
    settle();

    // loading the count with a sleeper present leaves the permit count unchanged
    write_reg(cswq_pkg::REG_INITIAL_PERMITS, 16'hFFFF);
    write_reg(cswq_pkg::REG_PERMIT_LIMIT, 16'hFFFF);
    end_writes();
    queue_traffic(45, 3000);
    settle();

    // tight limit: frequent sleeping and waking; one long receiver hold-off
    write_reg(cswq_pkg::REG_PERMIT_LIMIT, 16'd40);
    write_reg(cswq_pkg::REG_INITIAL_PERMITS, 16'd40);
    end_writes();
    hold_armed = 1'b1;
    queue_traffic(60, 12);
    settle();

    // flush all sleepers at the full limit, back to back with no idling
    write_reg(cswq_pkg::REG_PERMIT_LIMIT, 16'hFFFF);
    end_writes();
    gappy = 1'b0;
    for (t = 0; t < QUEUE_SLOTS; t++) begin
      queue_word(cswq_pkg::MODE_RELEASE, THR_W'(t * 16), 16'hFFFF);
    end
    settle();

    // counter loaded far above a freshly lowered limit; the next release clamps
    write_reg(cswq_pkg::REG_INITIAL_PERMITS, 16'd60000);
    write_reg(cswq_pkg::REG_PERMIT_LIMIT, 16'd100);
    end_writes();
    queue_traffic(45, 30);
    settle();

    // zero limit: releases add nothing, acquires pile up
    gappy = 1'b1;
    write_reg(cswq_pkg::REG_PERMIT_LIMIT, 16'd0);
    write_reg(cswq_pkg::REG_INITIAL_PERMITS, 16'd0);
    end_writes();
    queue_traffic(30, 4);
    settle();

    // a random setting to finish
    lim_pick = $urandom_range(1, 65534);
    write_reg(cswq_pkg::REG_PERMIT_LIMIT, DAT_W'(lim_pick));
    write_reg(cswq_pkg::REG_INITIAL_PERMITS, DAT_W'($urandom_range(0, 65535)));
    end_writes();
    queue_traffic(50, lim_pick / 8 + 1);
    settle();

    $display("%0d request words in, %0d response words out", n_words_in, n_words_out);
    $display("granted %0d, queued %0d, turned away %0d, woken %0d",
             n_granted, n_queued, n_rejected, n_woken);
    if (errors == 0 && due_words.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/cswq_pkg.sv
src/cswq_wait_mem.sv
src/cswq_rsp_reg.sv
src/counting_semaphore_waiter_queue.sv
src/cswq_checker.sv
bench/tb.sv
